/* hdl/ehpd_pkg.sv */
// ehpd_pkg: shared types and constants for the eh pointer decoder
// no dependencies; used by the channel interfaces and the top level
package ehpd_pkg;

  // encoding byte fields
  localparam logic [7:0] APP_MASK  = 8'h70;
  localparam logic [7:0] FMT_MASK  = 8'h0F;
  localparam logic [7:0] APP_ABS   = 8'h00;
  localparam logic [7:0] APP_PCREL = 8'h10;

  // pointer formats (low nibble of the encoding)
  localparam logic [3:0] FMT_ABSPTR = 4'h0;
  localparam logic [3:0] FMT_ULEB   = 4'h1;
  localparam logic [3:0] FMT_UDATA2 = 4'h2;
  localparam logic [3:0] FMT_UDATA4 = 4'h3;
  localparam logic [3:0] FMT_UDATA8 = 4'h4;
  localparam logic [3:0] FMT_SIGNED = 4'h8;
  localparam logic [3:0] FMT_SLEB   = 4'h9;
  localparam logic [3:0] FMT_SDATA2 = 4'hA;
  localparam logic [3:0] FMT_SDATA4 = 4'hB;
  localparam logic [3:0] FMT_SDATA8 = 4'hC;

  // longest leb field in bytes
  localparam logic [3:0] LEB_MAX_BYTES = 4'd10;

  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ENCODING        = 3'd0,
    REG_BASE_VALUE      = 3'd1,
    REG_SECTION_ADDRESS = 3'd2,
    REG_WIDE_POINTERS   = 3'd3,
    REG_BIG_ENDIAN      = 3'd4
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_ENC  = 2'd1,
    ST_LEB_LONG = 2'd2
  } status_t;

  // completed field, leaving the byte stage
  typedef struct packed {
    logic [63:0] value;
    logic        pcrel;
    logic        app_bad;
    status_t     status;
    logic [3:0]  nbytes;
    logic        indirect;
    logic [31:0] start;
  } fld_t;

  // field with its base selected, ahead of the final add
  typedef struct packed {
    logic [63:0] value;
    logic [63:0] base;
    logic        zero;
    status_t     status;
    logic [3:0]  nbytes;
    logic        indirect;
  } sum_t;

endpackage

/* hdl/ehpd_if.sv */
// ehpd_if: valid/ready channel interfaces of the eh pointer decoder
// depends on ehpd_pkg
interface ehpd_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  data_byte;
  logic [31:0] byte_offset;

  modport source (output valid, output data_byte, output byte_offset, input ready);
  modport sink   (input valid, input data_byte, input byte_offset, output ready);
endinterface

interface ehpd_out_if;
  logic               valid;
  logic               ready;
  logic [63:0]        pointer_value;
  logic               is_indirect;
  ehpd_pkg::status_t  status;
  logic [3:0]         field_bytes;

  modport source (output valid, output pointer_value, output is_indirect, output status,
                  output field_bytes, input ready);
  modport sink   (input valid, input pointer_value, input is_indirect, input status,
                  input field_bytes, output ready);
endinterface

interface ehpd_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [ehpd_pkg::CFG_IDX_W-1:0] index;
  logic [63:0]                    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

/* hdl/eh_pointer_decoder.sv */
// eh_pointer_decoder: streaming decoder of exception-handling encoded pointers
// depends on ehpd_pkg and the channel interfaces in ehpd_if.sv
//
// Section bytes come in on in_if, one per transfer, and the decoder takes a new
// byte in every cycle, including while a finished pointer waits on out_if. Each
// byte is folded into the field accumulator in the cycle it is taken; the byte
// that completes a field (or an unknown format byte, or the tenth byte of an
// overlong leb field) yields one result. A result passes from its last byte
// through the byte stage, the base select stage, then the 64-bit base add
// into the output register. Sustained rate is one byte per cycle; stalls on
// out_if ripple back to in_if.ready only once all three stages are full.
// Configuration writes on cfg_if are always taken; writing encoding,
// wide_pointers or big_endian drops any half-gathered field. Write the
// configuration only while the decoder is drained. Results: pointer 0 for a
// zero raw value, status 1 for a disallowed encoding (unknown format, or a
// nonzero value with an application other than absolute or pc-relative) and
// status 2 for a leb field longer than ten bytes, with pointer 0 in both cases.
module eh_pointer_decoder (
  input  logic               clk,
  input  logic               rst_n,
  ehpd_in_if.sink            in_if,
  ehpd_out_if.source         out_if,
  ehpd_cfg_if.sink           cfg_if
);

  // configuration registers
  logic [7:0]  enc_r;
  logic [63:0] base_r;
  logic [63:0] sec_r;
  logic        wide_r;
  logic        big_r;

  // field gathering state
  logic [63:0] acc_r,   acc_nxt;
  logic [3:0]  taken_r, taken_nxt;
  logic [31:0] start_r, start_nxt;

  // pipeline stages
  ehpd_pkg::fld_t fld_r, fld_nxt;
  ehpd_pkg::sum_t sum_r, sum_nxt;
  logic           v1_r, v2_r, v3_r;
  logic           adv1, adv2, adv3;
  logic           emit;
  logic           in_fire, cfg_fire;
  logic           cfg_clr;

  // byte stage decode
  logic [3:0]  fmt;
  logic [7:0]  app;
  logic        known, leb, sgn;
  logic [3:0]  size;
  logic        first;
  logic [63:0] acc_base;
  logic [31:0] start_cur;
  logic [3:0]  n_nxt;
  logic [6:0]  leb_sh, ext_sh;
  logic [63:0] leb_acc, leb_val, fix_acc, fix_val;
  logic [7:0]  b;

  // final add
  logic [63:0] pv_nxt;

  // handshakes: each stage moves when the one after it is empty or moving
  assign adv3      = !v3_r || out_if.ready;
  assign adv2      = !v2_r || adv3;
  assign adv1      = !v1_r || adv2;
  assign in_if.ready  = adv1;
  assign cfg_if.ready = 1'b1;
  assign in_fire   = in_if.valid && in_if.ready;
  assign cfg_fire  = cfg_if.valid && cfg_if.ready;
  assign b         = in_if.data_byte;

  // a write to the encoding or field layout registers drops the partial field
  assign cfg_clr   = cfg_fire && ((cfg_if.index == ehpd_pkg::REG_ENCODING) ||
                                  (cfg_if.index == ehpd_pkg::REG_WIDE_POINTERS) ||
                                  (cfg_if.index == ehpd_pkg::REG_BIG_ENDIAN));

  // byte stage: fold the byte into the field, detect completion
  always_comb begin
    fmt   = enc_r[3:0];
    app   = enc_r & ehpd_pkg::APP_MASK;
    known = 1'b1;
    leb   = 1'b0;
    sgn   = 1'b0;
    size  = 4'd4;
    case (fmt)
      ehpd_pkg::FMT_ABSPTR: size = wide_r ? 4'd8 : 4'd4;
      ehpd_pkg::FMT_ULEB:   leb  = 1'b1;
      ehpd_pkg::FMT_UDATA2: size = 4'd2;
      ehpd_pkg::FMT_UDATA4: size = 4'd4;
      ehpd_pkg::FMT_UDATA8: size = 4'd8;
      ehpd_pkg::FMT_SIGNED: begin
        size = wide_r ? 4'd8 : 4'd4;
        sgn  = 1'b1;
      end
      ehpd_pkg::FMT_SLEB: begin
        leb = 1'b1;
        sgn = 1'b1;
      end
      ehpd_pkg::FMT_SDATA2: begin
        size = 4'd2;
        sgn  = 1'b1;
      end
      ehpd_pkg::FMT_SDATA4: begin
        size = 4'd4;
        sgn  = 1'b1;
      end
      ehpd_pkg::FMT_SDATA8: begin
        size = 4'd8;
        sgn  = 1'b1;
      end
      default: known = 1'b0;
    endcase

    first     = (taken_r == 4'd0);
    acc_base  = first ? 64'd0 : acc_r;
    start_cur = first ? in_if.byte_offset : start_r;
    n_nxt     = taken_r + 4'd1;

    // leb: seven bits a byte, bits past 63 dropped
    leb_sh  = 7'(taken_r) * 7'd7;
    leb_acc = acc_base;
    if (leb_sh < 7'd64) begin
      leb_acc = acc_base | (64'(b[6:0]) << leb_sh[5:0]);
    end
    ext_sh  = 7'(n_nxt) * 7'd7;
    leb_val = leb_acc;
    if (sgn && (ext_sh < 7'd64) && b[6]) begin
      leb_val = leb_acc | ({64{1'b1}} << ext_sh[5:0]);
    end

    // fixed fields in either byte order
    fix_acc = big_r ? {acc_base[55:0], b}
                    : (acc_base | (64'(b) << {taken_r[2:0], 3'b000}));
    fix_val = fix_acc;
    if (sgn && (size == 4'd2) && fix_acc[15]) begin
      fix_val[63:16] = '1;
    end
    if (sgn && (size == 4'd4) && fix_acc[31]) begin
      fix_val[63:32] = '1;
    end

    emit      = 1'b0;
    acc_nxt   = acc_r;
    taken_nxt = taken_r;
    start_nxt = start_r;
    fld_nxt.value    = 64'd0;
    fld_nxt.pcrel    = (app == ehpd_pkg::APP_PCREL);
    fld_nxt.app_bad  = (app != ehpd_pkg::APP_ABS) && (app != ehpd_pkg::APP_PCREL);
    fld_nxt.status   = ehpd_pkg::ST_OK;
    fld_nxt.nbytes   = n_nxt;
    fld_nxt.indirect = enc_r[7];
    fld_nxt.start    = start_cur;

    if (!known) begin
      // every byte of an unknown format is its own error result
      emit           = 1'b1;
      fld_nxt.status = ehpd_pkg::ST_BAD_ENC;
      fld_nxt.nbytes = 4'd1;
      acc_nxt        = 64'd0;
      taken_nxt      = 4'd0;
    end else if (leb) begin
      if (b[7]) begin
        if (n_nxt >= ehpd_pkg::LEB_MAX_BYTES) begin
          emit           = 1'b1;
          fld_nxt.status = ehpd_pkg::ST_LEB_LONG;
          fld_nxt.nbytes = ehpd_pkg::LEB_MAX_BYTES;
          acc_nxt        = 64'd0;
          taken_nxt      = 4'd0;
        end else begin
          acc_nxt   = leb_acc;
          taken_nxt = n_nxt;
          start_nxt = start_cur;
        end
      end else begin
        emit          = 1'b1;
        fld_nxt.value = leb_val;
        acc_nxt       = 64'd0;
        taken_nxt     = 4'd0;
      end
    end else if (n_nxt < size) begin
      acc_nxt   = fix_acc;
      taken_nxt = n_nxt;
      start_nxt = start_cur;
    end else begin
      emit          = 1'b1;
      fld_nxt.value = fix_val;
      acc_nxt       = 64'd0;
      taken_nxt     = 4'd0;
    end
  end

  // base select stage: pick the base, flag a zero raw value
  always_comb begin
    sum_nxt.value    = fld_r.value;
    sum_nxt.base     = fld_r.pcrel ? (sec_r + {32'd0, fld_r.start}) : base_r;
    sum_nxt.zero     = (fld_r.value == 64'd0);
    sum_nxt.status   = fld_r.status;
    sum_nxt.nbytes   = fld_r.nbytes;
    sum_nxt.indirect = fld_r.indirect;
    // unsupported application only matters for a nonzero value
    if ((fld_r.status == ehpd_pkg::ST_OK) && fld_r.app_bad && (fld_r.value != 64'd0)) begin
      sum_nxt.status = ehpd_pkg::ST_BAD_ENC;
    end
  end

  // final add into the output register
  always_comb begin
    if (sum_r.zero || (sum_r.status != ehpd_pkg::ST_OK)) begin
      pv_nxt = 64'd0;
    end else begin
      pv_nxt = sum_r.base + sum_r.value;
    end
  end

  // configuration and field state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enc_r   <= 8'd0;
      base_r  <= 64'd0;
      sec_r   <= 64'd0;
      wide_r  <= 1'b0;
      big_r   <= 1'b0;
      taken_r <= 4'd0;
    end else begin
      if (cfg_clr) begin
        taken_r <= 4'd0;
      end else if (in_fire) begin
        taken_r <= taken_nxt;
      end
      if (cfg_fire) begin
        case (ehpd_pkg::cfg_reg_t'(cfg_if.index))
          ehpd_pkg::REG_ENCODING:        enc_r  <= cfg_if.data[7:0];
          ehpd_pkg::REG_BASE_VALUE:      base_r <= cfg_if.data;
          ehpd_pkg::REG_SECTION_ADDRESS: sec_r  <= cfg_if.data;
          ehpd_pkg::REG_WIDE_POINTERS:   wide_r <= cfg_if.data[0];
          ehpd_pkg::REG_BIG_ENDIAN:      big_r  <= cfg_if.data[0];
          default: ;
        endcase
      end
    end
  end

  // accumulator and start offset need no reset: masked while taken_r is zero
  always_ff @(posedge clk) begin
    if (in_fire) begin
      acc_r   <= acc_nxt;
      start_r <= start_nxt;
    end
  end

  // stage valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (adv1) begin
        v1_r <= in_fire && emit;
      end
      if (adv2) begin
        v2_r <= v1_r;
      end
      if (adv3) begin
        v3_r <= v2_r;
      end
    end
  end

  // stage payloads
  always_ff @(posedge clk) begin
    if (adv1) begin
      fld_r <= fld_nxt;
    end
    if (adv2) begin
      sum_r <= sum_nxt;
    end
    if (adv3) begin
      out_if.pointer_value <= pv_nxt;
      out_if.is_indirect   <= sum_r.indirect;
      out_if.status        <= sum_r.status;
      out_if.field_bytes   <= sum_r.nbytes;
    end
  end

  assign out_if.valid = v3_r;

  // a partly gathered field never holds ten or more bytes
  a_taken_range: assert property (@(posedge clk) disable iff (!rst_n)
    taken_r < ehpd_pkg::LEB_MAX_BYTES)
    else $error("field byte count out of range");

  // every error result carries a zero pointer
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_if.valid && (out_if.status != ehpd_pkg::ST_OK)) |-> (out_if.pointer_value == 64'd0))
    else $error("error result with nonzero pointer");

  // overlong leb results always report ten bytes
  a_leb_long: assert property (@(posedge clk) disable iff (!rst_n)
    (out_if.valid && (out_if.status == ehpd_pkg::ST_LEB_LONG))
      |-> (out_if.field_bytes == ehpd_pkg::LEB_MAX_BYTES))
    else $error("overlong leb result with wrong byte count");

  // an encoding write drops the partial field
  a_enc_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_fire && (cfg_if.index == ehpd_pkg::REG_ENCODING)) |=> (taken_r == 4'd0))
    else $error("encoding write left a partial field");

endmodule

/* tb/sv/eh_pointer_decoder_checker.sv */
`timescale 1ns / 100ps
// eh_pointer_decoder_checker: watches the byte, result and register channels,
// predicts every decoded pointer and compares it with what the decoder returns
// depends on ehpd_pkg and the channel interfaces in ehpd_if.sv
module eh_pointer_decoder_checker
  import ehpd_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  ehpd_in_if   in_ch,
  ehpd_out_if  out_ch,
  ehpd_cfg_if  cfg_ch,
  output int   mismatch_cnt,
  output int   pending_cnt
);

  typedef struct packed {
    logic [63:0] ptr;
    logic        indirect;
    status_t     status;
    logic [3:0]  nbytes;
  } ptr_result_t;

  ptr_result_t expected_ptrs[$];

  // shadow registers
  logic [7:0]  enc_reg;
  logic [63:0] base_reg;
  logic [63:0] sect_reg;
  logic        wide_reg;
  logic        big_reg;

  // field being gathered
  logic [63:0] acc_reg;
  logic [3:0]  taken_reg;
  logic [31:0] start_off;

  task automatic drop_field();
    acc_reg   = '0;
    taken_reg = '0;
  endtask

  task automatic record(input logic [63:0] ptr, input status_t st, input logic [3:0] nb);
    ptr_result_t r;
    r.ptr      = ptr;
    r.indirect = enc_reg[7];
    r.status   = st;
    r.nbytes   = nb;
    expected_ptrs = {expected_ptrs, r};
  endtask

  // fold one section byte into the field, queue a pointer when it completes
  task automatic decode_byte(input logic [7:0] b, input logic [31:0] off);
    logic [7:0]  app;
    int unsigned width;
    int unsigned n;
    int unsigned shift;
    bit          is_leb;
    bit          is_sgn;
    logic [63:0] raw;
    app    = enc_reg & APP_MASK;
    width  = 0;
    is_leb = 1'b0;
    is_sgn = 1'b0;
    case (enc_reg[3:0])
      FMT_ABSPTR: width = wide_reg ? 8 : 4;
      FMT_ULEB:   is_leb = 1'b1;
      FMT_UDATA2: width = 2;
      FMT_UDATA4: width = 4;
      FMT_UDATA8: width = 8;
      FMT_SIGNED: begin
        width  = wide_reg ? 8 : 4;
        is_sgn = 1'b1;
      end
      FMT_SLEB: begin
        is_leb = 1'b1;
        is_sgn = 1'b1;
      end
      FMT_SDATA2: begin
        width  = 2;
        is_sgn = 1'b1;
      end
      FMT_SDATA4: begin
        width  = 4;
        is_sgn = 1'b1;
      end
      FMT_SDATA8: begin
        width  = 8;
        is_sgn = 1'b1;
      end
      default: begin
        // unknown format, every byte is rejected on its own
        drop_field();
        record('0, ST_BAD_ENC, 4'd1);
        return;
      end
    endcase

    if (taken_reg == 0) begin
      start_off = off;
      acc_reg   = '0;
    end
    n = taken_reg;

    if (is_leb) begin
      shift = 7 * n;
      if (shift < 64) acc_reg = acc_reg | ({57'd0, b[6:0]} << shift);
      n++;
      if (b[7]) begin
        if (n >= LEB_MAX_BYTES) begin
          drop_field();
          record('0, ST_LEB_LONG, LEB_MAX_BYTES);
        end else begin
          taken_reg = n[3:0];
        end
        return;
      end
      raw   = acc_reg;
      shift = 7 * n;
      if (is_sgn && shift < 64 && b[6]) raw = raw | ({64{1'b1}} << shift);
    end else begin
      if (big_reg) acc_reg = {acc_reg[55:0], b};
      else         acc_reg = acc_reg | ({56'd0, b} << ((8 * n) & 63));
      n++;
      if (n < width) begin
        taken_reg = n[3:0];
        return;
      end
      raw = acc_reg;
      if (is_sgn && width < 8 && raw[8 * width - 1])
        raw = raw | ({64{1'b1}} << (8 * width));
    end

    drop_field();
    if (raw == 0)                                  record('0, ST_OK, n[3:0]);
    else if (app != APP_ABS && app != APP_PCREL)   record('0, ST_BAD_ENC, n[3:0]);
    else if (app == APP_PCREL)                     record(sect_reg + {32'd0, start_off} + raw,
                                                          ST_OK, n[3:0]);
    else                                           record(base_reg + raw, ST_OK, n[3:0]);
  endtask

  always @(posedge clk) begin
    ptr_result_t want;
    if (!rst_n) begin
      enc_reg      = '0;
      base_reg     = '0;
      sect_reg     = '0;
      wide_reg     = 1'b0;
      big_reg      = 1'b0;
      start_off    = '0;
      mismatch_cnt = 0;
      drop_field();
      expected_ptrs.delete();
    end else begin
      // results first: a byte never yields its pointer in the same cycle
      if (out_ch.valid && out_ch.ready) begin
        if (expected_ptrs.size() == 0) begin
          $error("unexpected result: pointer_value %h status %0d", out_ch.pointer_value,
                 out_ch.status);
          mismatch_cnt++;
        end else begin
          want = expected_ptrs.pop_front();
          if (out_ch.pointer_value !== want.ptr) begin
            $error("pointer_value: expected %h, got %h", want.ptr, out_ch.pointer_value);
            mismatch_cnt++;
          end
          if (out_ch.is_indirect !== want.indirect) begin
            $error("is_indirect: expected %0b, got %0b", want.indirect, out_ch.is_indirect);
            mismatch_cnt++;
          end
          if (out_ch.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_ch.status);
            mismatch_cnt++;
          end
          if (out_ch.field_bytes !== want.nbytes) begin
            $error("field_bytes: expected %0d, got %0d", want.nbytes, out_ch.field_bytes);
            mismatch_cnt++;
          end
        end
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_reg_t'(cfg_ch.index))
          REG_ENCODING: begin
            enc_reg = cfg_ch.data[7:0];
            drop_field();
          end
          REG_BASE_VALUE:      base_reg = cfg_ch.data;
          REG_SECTION_ADDRESS: sect_reg = cfg_ch.data;
          REG_WIDE_POINTERS: begin
            wide_reg = cfg_ch.data[0];
            drop_field();
          end
          REG_BIG_ENDIAN: begin
            big_reg = cfg_ch.data[0];
            drop_field();
          end
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) decode_byte(in_ch.data_byte, in_ch.byte_offset);
    end
    pending_cnt = expected_ptrs.size();
  end

endmodule

/* tb/sv/eh_pointer_decoder_test.sv */
`timescale 1ns / 100ps
// eh_pointer_decoder_test: drives section bytes and register writes into the
// decoder with random gaps and stalls; the checker beside it judges the results
// depends on ehpd_pkg, ehpd_if.sv, eh_pointer_decoder and eh_pointer_decoder_checker
module eh_pointer_decoder_test;
  import ehpd_pkg::*;

  // encoding pieces the package does not name
  localparam logic [7:0] ENC_INDIRECT    = 8'h80;
  localparam logic [7:0] APP_UNSUPPORTED = 8'h30;
  localparam logic [3:0] FMT_UNKNOWN     = 4'hD;

  localparam int unsigned ITEM_TARGET = 1300;

  localparam logic [3:0] KNOWN_FMTS [10] = '{FMT_ABSPTR, FMT_ULEB, FMT_UDATA2, FMT_UDATA4,
                                             FMT_UDATA8, FMT_SIGNED, FMT_SLEB, FMT_SDATA2,
                                             FMT_SDATA4, FMT_SDATA8};

  logic clk = 1'b0;
  logic rst_n;

  ehpd_in_if  in_ch ();
  ehpd_out_if out_ch ();
  ehpd_cfg_if cfg_ch ();

  int mismatch_cnt;
  int pending_cnt;

  // stimulus state
  bit          quiet_in;      // no gaps between bytes for this phase
  bit          quiet_out;     // no result stalls for this phase
  int unsigned items_sent;
  logic [31:0] next_off;
  logic [7:0]  cur_enc;
  logic        cur_wide;

  eh_pointer_decoder i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch),
    .cfg_if (cfg_ch)
  );

  eh_pointer_decoder_checker i_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ch        (in_ch),
    .out_ch       (out_ch),
    .cfg_ch       (cfg_ch),
    .mismatch_cnt (mismatch_cnt),
    .pending_cnt  (pending_cnt)
  );

  always #2 clk = ~clk;

  // hard stop well beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

  function automatic logic [7:0] make_enc(input bit ind, input logic [7:0] app,
                                          input logic [3:0] fmt);
    return {ind, app[6:4], fmt};
  endfunction

  // 64-bit register value, often at one of the extremes
  function automatic logic [63:0] pick_wide_value();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // all drive tasks start and end at a falling edge
  task automatic write_reg(input cfg_reg_t idx, input logic [63:0] val);
    cfg_ch.valid = 1'b1;
    cfg_ch.index = idx;
    cfg_ch.data  = val;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid = 1'b0;
    if (idx == REG_ENCODING)      cur_enc  = val[7:0];
    if (idx == REG_WIDE_POINTERS) cur_wide = val[0];
  endtask

  // one byte transfer; valid stays high when the next byte follows without a gap
  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    gap = quiet_in ? 0 : $urandom_range(0, 15);
    if (gap != 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid       = 1'b1;
    in_ch.data_byte   = b;
    in_ch.byte_offset = next_off;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
    next_off++;
    items_sent++;
  endtask

  // wait until every pointer is back and the pipeline has emptied, so that a
  // field still sitting in the byte stage does not meet a register write
  task automatic settle();
    in_ch.valid = 1'b0;
    while (pending_cnt != 0) @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  // one pointer field for the current encoding, now and then a broken one
  task automatic send_field();
    logic [3:0]  fmt;
    int unsigned len;
    int unsigned kind;
    bit          leb;
    bit          overlong;
    logic [7:0]  b;
    fmt  = cur_enc[3:0];
    kind = $urandom_range(0, 15);
    leb  = (fmt == FMT_ULEB) || (fmt == FMT_SLEB);
    case (fmt)
      FMT_ABSPTR, FMT_SIGNED: len = cur_wide ? 8 : 4;
      FMT_UDATA2, FMT_SDATA2: len = 2;
      FMT_UDATA4, FMT_SDATA4: len = 4;
      FMT_UDATA8, FMT_SDATA8: len = 8;
      FMT_ULEB, FMT_SLEB:     len = (kind == 1) ? LEB_MAX_BYTES : $urandom_range(1, 10);
      default:                len = 1;
    endcase
    overlong = leb && (kind == 1);
    // noise: a few bytes with no regard for the field layout
    if (kind == 15) len = $urandom_range(1, 3);
    for (int i = 0; i < len; i++) begin
      case (kind)
        0:       b = 8'h00;   // zero raw value
        2:       b = 8'hFF;   // all ones, negative when signed
        default: b = 8'($urandom);
      endcase
      // leb continuation bits follow the chosen length
      if (leb && kind != 15) b[7] = overlong || (i < len - 1);
      send_byte(b);
    end
  endtask

  // fresh register setting for a random phase
  task automatic pick_setting();
    logic [3:0] fmt;
    logic [7:0] app;
    if ($urandom_range(0, 9) == 0) fmt = 4'($urandom);
    else                           fmt = KNOWN_FMTS[$urandom_range(0, 9)];
    case ($urandom_range(0, 5))
      0, 1, 2: app = APP_ABS;
      3, 4:    app = APP_PCREL;
      default: app = 8'($urandom) & APP_MASK;
    endcase
    if ($urandom_range(0, 3) != 0) write_reg(REG_BASE_VALUE, pick_wide_value());
    if ($urandom_range(0, 3) != 0) write_reg(REG_SECTION_ADDRESS, pick_wide_value());
    if ($urandom_range(0, 2) != 0) write_reg(REG_WIDE_POINTERS, 64'($urandom_range(0, 1)));
    if ($urandom_range(0, 2) != 0) write_reg(REG_BIG_ENDIAN, 64'($urandom_range(0, 1)));
    write_reg(REG_ENCODING, {56'd0, make_enc($urandom_range(0, 1), app, fmt)});
    quiet_in  = ($urandom_range(0, 3) == 0);
    quiet_out = ($urandom_range(0, 3) == 0);
  endtask

  // result side: a fresh stall before every pointer
  initial begin
    int unsigned stall;
    out_ch.ready = 1'b0;
    @(negedge clk);
    while (rst_n !== 1'b1) @(negedge clk);
    forever begin
      stall = quiet_out ? 0 : $urandom_range(0, 15);
      if (stall != 0) begin
        out_ch.ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ch.ready = 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      @(negedge clk);
    end
  end

  initial begin
    in_ch.valid       = 1'b0;
    in_ch.data_byte   = '0;
    in_ch.byte_offset = '0;
    cfg_ch.valid      = 1'b0;
    cfg_ch.index      = REG_ENCODING;
    cfg_ch.data       = '0;
    rst_n             = 1'b0;
    quiet_in          = 1'b0;
    quiet_out         = 1'b0;
    items_sent        = 0;
    next_off          = '0;
    cur_enc           = '0;
    cur_wide          = 1'b0;
    repeat (11) @(negedge clk);
    rst_n = 1'b1;

    // reset setting: 4-byte absolute pointer, zero raw value gives zero
    repeat (4) send_byte(8'h00);
    settle();

    // all-ones bases, wide big-endian, indirect pc-relative sdata4;
    // the field starts just below the top of the offset range and wraps
    write_reg(REG_BASE_VALUE, '1);
    write_reg(REG_SECTION_ADDRESS, '1);
    write_reg(REG_WIDE_POINTERS, 64'd1);
    write_reg(REG_BIG_ENDIAN, 64'd1);
    write_reg(REG_ENCODING, {56'd0, make_enc(1'b1, APP_PCREL, FMT_SDATA4)});
    next_off = 32'hFFFF_FFFE;
    send_byte(8'h80);
    send_byte(8'h00);
    send_byte(8'h00);
    send_byte(8'h01);

    // section address changed mid-field keeps the half field, used at the end
    send_byte(8'hFF);
    send_byte(8'hFF);
    settle();
    write_reg(REG_SECTION_ADDRESS, '0);
    send_byte(8'hFF);
    send_byte(8'hFE);
    settle();

    // unsupported application; encoding rewritten mid-field drops the half field
    write_reg(REG_ENCODING, {56'd0, make_enc(1'b0, APP_UNSUPPORTED, FMT_UDATA2)});
    send_byte(8'h55);
    settle();
    write_reg(REG_ENCODING, {56'd0, make_enc(1'b0, APP_UNSUPPORTED, FMT_UDATA2)});
    send_byte(8'h00);
    send_byte(8'h00);   // zero still passes
    send_byte(8'h12);
    send_byte(8'h34);   // nonzero is rejected
    settle();

    // unknown format rejects each byte on its own
    write_reg(REG_ENCODING, {56'd0, make_enc(1'b1, APP_ABS, FMT_UNKNOWN)});
    send_byte(8'hFF);
    settle();

    // overlong uleb, then a one-byte field right behind it
    write_reg(REG_ENCODING, {56'd0, make_enc(1'b0, APP_ABS, FMT_ULEB)});
    repeat (10) send_byte(8'hFF);
    send_byte(8'h7F);

    // random phases: mostly well-formed fields, some noise
    while (items_sent < ITEM_TARGET) begin
      settle();
      pick_setting();
      next_off = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 20)
                                             : 32'($urandom);
      repeat ($urandom_range(4, 20)) send_field();
    end

    // drain with a bound, then let the pipeline run empty
    in_ch.valid = 1'b0;
    for (int w = 0; w < 4000 && pending_cnt != 0; w++) @(negedge clk);
    repeat (8) @(negedge clk);
    if (mismatch_cnt == 0 && pending_cnt == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
